FILE: rtl/gpeg_pkg.sv
`timescale 1ns / 1ps
package gpeg_pkg;
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic sub;
        logic swap;
        logic up;
        logic down;
    } t_ctl;
endpackage

FILE: rtl/gpeg_cell.sv
`timescale 1ns / 1ps
module gpeg_cell
    import gpeg_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  logic i_r_in,
    input  logic i_s_in,
    input  logic i_t_in,
    input  logic i_u_in,
    input  logic i_v_in,
    input  logic i_w_in,
    input  logic i_u_lo,
    input  logic i_v_lo,
    input  logic i_w_lo,
    input  logic i_u_hi,
    input  logic i_v_hi,
    input  logic i_w_hi,
    input  t_ctl i_ctl,
    output logic o_r,
    output logic o_s,
    output logic o_t,
    output logic o_u,
    output logic o_v,
    output logic o_w
);
    logic r_r, r_s, r_t, r_u, r_v, r_w;
    logic n_r, n_s, n_t, n_u, n_v, n_w;
    logic x_r, x_s, x_t;

    always_comb begin
        x_r = r_r ^ (i_ctl.sub & r_u);
        x_s = r_s ^ (i_ctl.sub & r_v);
        x_t = r_t ^ (i_ctl.sub & r_w);
        n_r = x_r;
        n_s = x_s;
        n_t = x_t;
        n_u = r_u;
        n_v = r_v;
        n_w = r_w;
        if (i_ctl.swap) begin
            n_r = r_u;
            n_s = r_v;
            n_t = r_w;
            n_u = x_r;
            n_v = x_s;
            n_w = x_t;
        end else if (i_ctl.up) begin
            n_u = i_u_lo;
            n_v = i_v_lo;
            n_w = i_w_lo;
        end else if (i_ctl.down) begin
            n_u = i_u_hi;
            n_v = i_v_hi;
            n_w = i_w_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_r <= i_r_in;
            r_s <= i_s_in;
            r_t <= i_t_in;
            r_u <= i_u_in;
            r_v <= i_v_in;
            r_w <= i_w_in;
        end else begin
            r_r <= n_r;
            r_s <= n_s;
            r_t <= n_t;
            r_u <= n_u;
            r_v <= n_v;
            r_w <= n_w;
        end
    end

    assign o_r = r_r;
    assign o_s = r_s;
    assign o_t = r_t;
    assign o_u = r_u;
    assign o_v = r_v;
    assign o_w = r_w;
endmodule

FILE: rtl/gf2_poly_extended_gcd.sv
`timescale 1ns / 1ps
// channel   dir  tdata fields (low bit up)
// s_axis    in   a_poly, b_poly
// m_axis    out  gcd_poly, s_coef, t_coef
// A row of POLY_BITS cells holds r0,s0,t0 and r1,s1,t1, one coefficient per cell.
// Each step shifts the divisor pair up a place, or subtracts it where the degrees match and
// shifts it down a place, or swaps the pairs once a division ends: at most 3*POLY_BITS-2 steps.
// Once the last step leaves the divisor at zero, the result is registered from the row when
// the output is free, else the block waits in ST_DONE; it takes a new item only in ST_IDLE.
// Synchronous active-low reset clears control; a stalled result holds the row.
module gf2_poly_extended_gcd
    import gpeg_pkg::*;
#(
    parameter int POLY_BITS = 9
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((2 * POLY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // a_poly, b_poly
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((3 * POLY_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata   // gcd_poly, s_coef, t_coef
);
    localparam int P = POLY_BITS;
    localparam int DW_OUT = ((3 * P + 7) / 8) * 8;
    localparam int KW = $clog2(P);

    function automatic logic [KW-1:0] deg(input logic [P-1:0] p);
        logic [KW-1:0] d;
        d = '0;
        for (int i = 0; i < P; i++) if (p[i]) d = KW'(i);
        return d;
    endfunction

    t_state r_state, n_state;
    logic load;
    logic done;
    logic free;
    t_ctl ctl;
    logic [KW-1:0] r_k, n_k;
    logic r_oval;
    logic [P-1:0] a_in, b_in;
    logic [P-1:0] cell_r, cell_s, cell_t, cell_u, cell_v, cell_w;
    logic [P-1:0] u_up, v_up, w_up, u_dn, v_dn, w_dn;
    logic [P-1:0] r_gcd, r_sc, r_tc;
    logic [KW-1:0] deg_r, deg_u;
    logic nz_r, nz_u;

    assign a_in = s_axis_tdata[P-1:0];
    assign b_in = s_axis_tdata[2*P-1:P];
    assign u_up = cell_u << 1;
    assign v_up = cell_v << 1;
    assign w_up = cell_w << 1;
    assign u_dn = cell_u >> 1;
    assign v_dn = cell_v >> 1;
    assign w_dn = cell_w >> 1;
    assign free = !r_oval || m_axis_tready;

    always_comb begin
        deg_r = deg(cell_r);
        deg_u = deg(cell_u);
        nz_r = |cell_r;
        nz_u = |cell_u;
    end

    for (genvar g = 0; g < P; g++) begin : g_cell
        gpeg_cell u_cell (
            .i_clk  (i_clk),
            .i_load (load),
            .i_r_in (a_in[g]),
            .i_s_in ((g == 0) ? 1'b1 : 1'b0),
            .i_t_in (1'b0),
            .i_u_in (b_in[g]),
            .i_v_in (1'b0),
            .i_w_in ((g == 0) ? 1'b1 : 1'b0),
            .i_u_lo (u_up[g]),
            .i_v_lo (v_up[g]),
            .i_w_lo (w_up[g]),
            .i_u_hi (u_dn[g]),
            .i_v_hi (v_dn[g]),
            .i_w_hi (w_dn[g]),
            .i_ctl  (ctl),
            .o_r    (cell_r[g]),
            .o_s    (cell_s[g]),
            .o_t    (cell_t[g]),
            .o_u    (cell_u[g]),
            .o_v    (cell_v[g]),
            .o_w    (cell_w[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_RUN;
            ST_RUN: begin
                if (!nz_u) n_state = free ? ST_IDLE : ST_DONE;
            end
            ST_DONE: if (free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        load = 1'b0;
        done = 1'b0;
        ctl = '0;
        n_k = r_k;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                load = s_axis_tvalid;
                n_k = '0;
            end
            ST_RUN: begin
                if (!nz_u) begin
                    done = free;
                end else if (nz_r && (deg_r > deg_u)) begin
                    ctl.up = 1'b1;
                    n_k = r_k + KW'(1);
                end else begin
                    ctl.sub = nz_r && (deg_r == deg_u);
                    if (r_k != '0) begin
                        ctl.down = 1'b1;
                        n_k = r_k - KW'(1);
                    end else begin
                        ctl.swap = 1'b1;
                    end
                end
            end
            ST_DONE: done = free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
            if (done) r_oval <= 1'b1;
            else if (m_axis_tready) r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_gcd <= cell_r;
            r_sc <= cell_s;
            r_tc <= cell_t;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = DW_OUT'({r_tc, r_sc, r_gcd});

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed under stall");

    property p_keep;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid;
    endproperty
    a_keep: assert property (p_keep) else $error("result dropped under stall");

    property p_start;
        @(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready;
    endproperty
    a_start: assert property (p_start) else $error("second item taken");
endmodule

FILE: dv/gf2_poly_extended_gcd_tb.sv
`timescale 1ns / 1ps
module gf2_poly_extended_gcd_tb;
    localparam int PB = 9;
    localparam int DW_IN = 24;
    localparam int DW_OUT = 32;
    localparam int N_RANDOM = 1250;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [PB-1:0] b_poly;
        logic [PB-1:0] a_poly;
    } t_pair;

    typedef struct packed {
        logic [PB-1:0] t_coef;
        logic [PB-1:0] s_coef;
        logic [PB-1:0] gcd_poly;
    } t_bezout;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DW_IN-1:0]  s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DW_OUT-1:0] m_axis_tdata;

    t_pair   pair_q[$];
    t_bezout bezout_q[$];
    int      n_sent;
    int      n_total;
    int      n_bad;
    int      cycles;
    bit      taken;
    bit      fill_done;

    gf2_poly_extended_gcd #(.POLY_BITS(PB)) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic int degree_of(logic [63:0] p);
        int d;
        d = -1;
        for (int k = 0; k < 64; k++) if (p[k]) d = k;
        return d;
    endfunction

    function automatic logic [63:0] clmul64(logic [63:0] x, logic [63:0] y);
        logic [63:0] acc;
        acc = '0;
        for (int k = 0; k < 64; k++) if (y[k]) acc ^= x << k;
        return acc;
    endfunction

    function automatic t_bezout bezout_of(t_pair p);
        logic [63:0] r0, r1, s0, s1, t0, t1, q, r, ns, nt;
        int dd, dr;
        t_bezout res;
        r0 = 64'(p.a_poly);
        r1 = 64'(p.b_poly);
        s0 = 1; s1 = 0; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            dd = degree_of(r1);
            q = 0;
            r = r0;
            dr = degree_of(r);
            while (dr >= dd) begin
                q |= 64'd1 << (dr - dd);
                r ^= r1 << (dr - dd);
                dr = degree_of(r);
            end
            ns = s0 ^ clmul64(q, s1);
            nt = t0 ^ clmul64(q, t1);
            r0 = r1; r1 = r;
            s0 = s1; s1 = ns;
            t0 = t1; t1 = nt;
        end
        res.gcd_poly = r0[PB-1:0];
        res.s_coef = s0[PB-1:0];
        res.t_coef = t0[PB-1:0];
        return res;
    endfunction

    function automatic logic [PB-1:0] rand_poly();
        case ($urandom_range(0, 3))
            0: return PB'($urandom_range(0, 15));
            1: return PB'($urandom_range(256, 511));
            default: return PB'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic [PB-1:0] a, logic [PB-1:0] b);
        t_pair p;
        p.a_poly = a;
        p.b_poly = b;
        pair_q.push_back(p);
        n_total++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        logic [PB-1:0] g, u, v;
        n_total = 0;
        fill_done = 0;
        add_pair('0, '0);
        add_pair(9'h1ff, '0);
        add_pair('0, 9'h1ff);
        add_pair('0, 9'h001);
        add_pair(9'h001, '0);
        add_pair(9'h001, 9'h001);
        add_pair(9'h1ff, 9'h001);
        add_pair(9'h001, 9'h1ff);
        add_pair(9'h1ff, 9'h1ff);
        add_pair(9'h100, 9'h001);
        add_pair(9'h100, 9'h100);
        add_pair(9'h11b, 9'h053);
        add_pair(9'h053, 9'h11b);
        add_pair(9'h100, 9'h0ff);
        add_pair(9'h0aa, 9'h155);
        add_pair(9'h155, 9'h0aa);
        add_pair(9'h002, 9'h003);
        add_pair(9'h180, 9'h0c0);
        add_pair(9'h1fe, 9'h002);
        add_pair(9'h0ff, 9'h100);
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                g = PB'($urandom_range(1, 31));
                u = PB'($urandom_range(0, 31));
                v = PB'($urandom_range(0, 31));
                add_pair(PB'(clmul64(64'(g), 64'(u))), PB'(clmul64(64'(g), 64'(v))));
            end else begin
                add_pair(rand_poly(), rand_poly());
            end
        end
        fill_done = 1;
    end

    function automatic int send_idle_pct();
        if (n_sent < n_total / 3) return 7;
        if (n_sent < 2 * n_total / 3) return 83;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_sent < n_total / 3) return 83;
        if (n_sent < 2 * n_total / 3) return 7;
        return 0;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        n_sent = 0;
        n_bad = 0;
        cycles = 0;
        taken = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
            if (!s_axis_tvalid || taken) begin
                if (pair_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= DW_IN'(pair_q[0]) ;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            taken = 0;
        end
    end

    always @(posedge i_clk) begin
        t_bezout got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            bezout_q.push_back(bezout_of(pair_q.pop_front()));
            n_sent++;
            taken = 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_bezout'(m_axis_tdata[3*PB-1:0]);
            if (bezout_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected item %h", got);
            end else begin
                want = bezout_q.pop_front();
                if (got.gcd_poly !== want.gcd_poly || got.s_coef !== want.s_coef
                        || got.t_coef !== want.t_coef) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: gcd %h/%h s %h/%h t %h/%h (exp/got)",
                                 want.gcd_poly, got.gcd_poly, want.s_coef, got.s_coef,
                                 want.t_coef, got.t_coef);
                end
            end
        end
    end

    initial begin
        wait (fill_done && i_rst_n);
        wait (pair_q.size() == 0 && bezout_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_bad == 0 && bezout_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/gpeg_pkg.sv
rtl/gpeg_cell.sv
rtl/gf2_poly_extended_gcd.sv
dv/gf2_poly_extended_gcd_tb.sv
